// File: sv/symmetric_quad_index_map_core_defines.svh
// ----------------------------------------------------------------------------
// symmetric quad index map: assertion macros
// concurrent checks clocked on aclk, held off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_QUAD_INDEX_MAP_CORE_DEFINES_SVH
`define SYMMETRIC_QUAD_INDEX_MAP_CORE_DEFINES_SVH

// same-cycle implication
`define SQIM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SQIM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sqim_pkg.sv
// ----------------------------------------------------------------------------
// sqim_pkg
// widths, stage schedule and pipeline word type of the symmetric quad index map
// ----------------------------------------------------------------------------
package sqim_pkg;

    localparam int MAX_BASIS   = 256;
    localparam int BASIS_RESET = 256;

    localparam int DIM_W    = 9;
    localparam int ORB_W    = 8;
    localparam int PACKED_W = 30;
    localparam int PAIR_W   = 16;

    // wide root works on 8*packed+1, narrow roots on 8*pair+1
    localparam int SQ1_W     = 34;
    localparam int SQ1_STEPS = 17;
    localparam int SQ2_W     = 20;
    localparam int SQ2_STEPS = 10;

    // stage schedule
    localparam int ST_ORDER   = 1;
    localparam int ST_ADD     = 2;
    localparam int SQ1_FIRST  = 2;
    localparam int SQ1_LAST   = SQ1_FIRST + SQ1_STEPS - 1;
    localparam int ST_ROOT1   = SQ1_LAST + 1;
    localparam int ST_SPLIT   = ST_ROOT1 + 1;
    localparam int SQ2_FIRST  = ST_SPLIT + 1;
    localparam int SQ2_LAST   = SQ2_FIRST + SQ2_STEPS - 1;
    localparam int ST_LAST    = SQ2_LAST + 1;
    localparam int NUM_STAGES = ST_LAST + 1;

    typedef struct packed {
        logic                act;
        logic                err;
        logic [PAIR_W-1:0]   pa;
        logic [PAIR_W-1:0]   pb;
        logic [PAIR_W-1:0]   npair;
        logic [PACKED_W-1:0] lim;
        logic [PACKED_W-1:0] idx;
        logic [PACKED_W-1:0] packed_val;
        logic [PACKED_W-1:0] tmn;
        logic [SQ1_W-1:0]    v1;
        logic [SQ1_W-1:0]    r1;
        logic [SQ2_W-1:0]    v2a;
        logic [SQ2_W-1:0]    r2a;
        logic [SQ2_W-1:0]    v2b;
        logic [SQ2_W-1:0]    r2b;
        logic [ORB_W-1:0]    mu;
        logic [ORB_W-1:0]    nu;
        logic [ORB_W-1:0]    lam;
        logic [ORB_W-1:0]    sig;
    } item_t;

endpackage

// File: sv/symmetric_quad_index_map_core.sv
// ----------------------------------------------------------------------------
// symmetric_quad_index_map_core
// four orbital indices to eightfold-symmetric packed integral index and back
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  s_       | in        | s_valid / s_ready  | action, four orbitals, packed_in
//  m_       | out       | m_valid / m_ready  | packed_out, four orbitals, range_error
//  cfg_     | in        | cfg_we, no wait    | basis_size
//
//  32 register stages; one word per cycle while m_ready does not stall the output
//  the depth comes from the 17-step wide root and the 10-step narrow roots,
//  one root bit per stage
//  aresetn (synchronous) empties the pipeline and sets basis_size to 256
//  a stall holds only stages behind a full stage; bubbles close up underneath
// ----------------------------------------------------------------------------
module symmetric_quad_index_map_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sqim_pkg::DIM_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_action,
    input  logic [sqim_pkg::ORB_W-1:0]     s_first_orbital,
    input  logic [sqim_pkg::ORB_W-1:0]     s_second_orbital,
    input  logic [sqim_pkg::ORB_W-1:0]     s_third_orbital,
    input  logic [sqim_pkg::ORB_W-1:0]     s_fourth_orbital,
    input  logic [sqim_pkg::PACKED_W-1:0]  s_packed_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sqim_pkg::PACKED_W-1:0]  m_packed_out,
    output logic [sqim_pkg::ORB_W-1:0]     m_mu_out,
    output logic [sqim_pkg::ORB_W-1:0]     m_nu_out,
    output logic [sqim_pkg::ORB_W-1:0]     m_lam_out,
    output logic [sqim_pkg::ORB_W-1:0]     m_sig_out,
    output logic                           m_range_error
);

    localparam int N = sqim_pkg::NUM_STAGES;

    // t(t+1)/2 for t up to 256
    function automatic logic [sqim_pkg::PAIR_W-1:0] tri_narrow(input logic [8:0] t);
        logic [17:0] prod;
        prod = 18'(t) * (18'(t) + 18'd1);
        return prod[16:1];
    endfunction

    // t(t+1)/2 for a pair index
    function automatic logic [sqim_pkg::PACKED_W-1:0] tri_wide(
        input logic [sqim_pkg::PAIR_W-1:0] t
    );
        logic [32:0] prod;
        prod = 33'(t) * (33'(t) + 33'd1);
        return prod[30:1];
    endfunction

    function automatic logic [sqim_pkg::PAIR_W-1:0] pair_of(
        input logic [sqim_pkg::ORB_W-1:0] a,
        input logic [sqim_pkg::ORB_W-1:0] b
    );
        logic [sqim_pkg::ORB_W-1:0] hi;
        logic [sqim_pkg::ORB_W-1:0] lo;
        hi = (a >= b) ? a : b;
        lo = (a >= b) ? b : a;
        return tri_narrow({1'b0, hi}) + sqim_pkg::PAIR_W'(lo);
    endfunction

    function automatic sqim_pkg::item_t stage_first(
        input logic                          act,
        input logic [sqim_pkg::ORB_W-1:0]    o1,
        input logic [sqim_pkg::ORB_W-1:0]    o2,
        input logic [sqim_pkg::ORB_W-1:0]    o3,
        input logic [sqim_pkg::ORB_W-1:0]    o4,
        input logic [sqim_pkg::PACKED_W-1:0] idx,
        input logic [sqim_pkg::DIM_W-1:0]    basis
    );
        sqim_pkg::item_t d;
        logic [sqim_pkg::DIM_W-1:0] dim;
        d   = '0;
        dim = (basis > sqim_pkg::DIM_W'(sqim_pkg::MAX_BASIS)) ?
              sqim_pkg::DIM_W'(sqim_pkg::MAX_BASIS) : basis;
        d.act   = act;
        d.err   = !act && (({1'b0, o1} >= dim) || ({1'b0, o2} >= dim) ||
                           ({1'b0, o3} >= dim) || ({1'b0, o4} >= dim));
        d.pa    = pair_of(o1, o2);
        d.pb    = pair_of(o3, o4);
        d.npair = tri_narrow(dim);
        d.idx   = idx;
        d.v1    = {1'b0, idx, 3'b001};
        d.r1    = '0;
        return d;
    endfunction

    function automatic sqim_pkg::item_t stage_fn(input int k, input sqim_pkg::item_t d);
        sqim_pkg::item_t n;
        logic [sqim_pkg::PAIR_W-1:0] hi;
        logic [sqim_pkg::PAIR_W-1:0] lo;
        logic [sqim_pkg::SQ1_W-1:0]  bit1;
        logic [sqim_pkg::SQ1_W-1:0]  sum1;
        logic [sqim_pkg::SQ2_W-1:0]  bit2;
        logic [sqim_pkg::SQ2_W-1:0]  suma;
        logic [sqim_pkg::SQ2_W-1:0]  sumb;
        logic [sqim_pkg::SQ1_W-1:0]  dec1;
        logic [sqim_pkg::SQ2_W-1:0]  deca;
        logic [sqim_pkg::SQ2_W-1:0]  decb;
        logic [sqim_pkg::PAIR_W-1:0] ls;
        logic [sqim_pkg::ORB_W-1:0]  mu;
        logic [sqim_pkg::ORB_W-1:0]  lam;
        n = d;
        if (k == sqim_pkg::ST_ORDER) begin
            hi = (d.pa >= d.pb) ? d.pa : d.pb;
            lo = (d.pa >= d.pb) ? d.pb : d.pa;
            n.packed_val = tri_wide(hi);
            n.pa  = lo;
            n.lim = tri_wide(d.npair);
        end
        if (k == sqim_pkg::ST_ADD) begin
            n.packed_val = d.packed_val + sqim_pkg::PACKED_W'(d.pa);
            if (d.act) begin
                n.err = (d.idx >= d.lim);
            end
        end
        // restoring square root, one result bit per stage
        if (k >= sqim_pkg::SQ1_FIRST && k <= sqim_pkg::SQ1_LAST) begin
            bit1 = sqim_pkg::SQ1_W'(1) << (2 * (sqim_pkg::SQ1_LAST - k));
            sum1 = d.r1 + bit1;
            if (d.v1 >= sum1) begin
                n.v1 = d.v1 - sum1;
                n.r1 = (d.r1 >> 1) + bit1;
            end else begin
                n.r1 = d.r1 >> 1;
            end
        end
        if (k == sqim_pkg::ST_ROOT1) begin
            dec1 = d.r1 - sqim_pkg::SQ1_W'(1);
            n.pa  = dec1[sqim_pkg::PAIR_W:1];
            n.tmn = tri_wide(dec1[sqim_pkg::PAIR_W:1]);
        end
        if (k == sqim_pkg::ST_SPLIT) begin
            ls    = sqim_pkg::PAIR_W'(d.idx - d.tmn);
            n.pb  = ls;
            n.v2a = {1'b0, d.pa, 3'b001};
            n.v2b = {1'b0, ls, 3'b001};
            n.r2a = '0;
            n.r2b = '0;
        end
        if (k >= sqim_pkg::SQ2_FIRST && k <= sqim_pkg::SQ2_LAST) begin
            bit2 = sqim_pkg::SQ2_W'(1) << (2 * (sqim_pkg::SQ2_LAST - k));
            suma = d.r2a + bit2;
            sumb = d.r2b + bit2;
            if (d.v2a >= suma) begin
                n.v2a = d.v2a - suma;
                n.r2a = (d.r2a >> 1) + bit2;
            end else begin
                n.r2a = d.r2a >> 1;
            end
            if (d.v2b >= sumb) begin
                n.v2b = d.v2b - sumb;
                n.r2b = (d.r2b >> 1) + bit2;
            end else begin
                n.r2b = d.r2b >> 1;
            end
        end
        if (k == sqim_pkg::ST_LAST) begin
            deca  = d.r2a - sqim_pkg::SQ2_W'(1);
            decb  = d.r2b - sqim_pkg::SQ2_W'(1);
            mu    = deca[sqim_pkg::ORB_W:1];
            lam   = decb[sqim_pkg::ORB_W:1];
            n.mu  = mu;
            n.lam = lam;
            n.nu  = sqim_pkg::ORB_W'(d.pa - tri_narrow({1'b0, mu}));
            n.sig = sqim_pkg::ORB_W'(d.pb - tri_narrow({1'b0, lam}));
            if (!d.act || d.err) begin
                n.mu  = '0;
                n.nu  = '0;
                n.lam = '0;
                n.sig = '0;
            end
            if (d.act || d.err) begin
                n.packed_val = '0;
            end
        end
        return n;
    endfunction

    logic [sqim_pkg::DIM_W-1:0] basis_reg;
    logic [sqim_pkg::DIM_W-1:0] basis_next;
    logic [N-1:0]               vld_reg;
    logic [N-1:0]               vld_next;
    logic [N:0]                 adv;
    logic [N-1:0]               vld_in;
    sqim_pkg::item_t            pipe_reg  [N];
    sqim_pkg::item_t            pipe_next [N];

    assign basis_next = cfg_we ? cfg_wdata : basis_reg;

    // a stage takes a word when it is empty or its successor moves
    assign adv[N]  = m_ready;
    assign vld_in  = {vld_reg[N-2:0], s_valid};

    genvar gk;
    generate
        for (gk = 0; gk < N; gk++) begin : g_stage
            assign adv[gk] = !vld_reg[gk] || adv[gk+1];
            if (gk == 0) begin : g_head
                assign pipe_next[gk] = stage_first(s_action, s_first_orbital,
                                                   s_second_orbital, s_third_orbital,
                                                   s_fourth_orbital, s_packed_in,
                                                   basis_reg);
            end else begin : g_body
                assign pipe_next[gk] = stage_fn(gk, pipe_reg[gk-1]);
            end
        end
    endgenerate

    always_comb begin
        for (int k = 0; k < N; k++) begin
            vld_next[k] = adv[k] ? vld_in[k] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            basis_reg <= sqim_pkg::DIM_W'(sqim_pkg::BASIS_RESET);
            vld_reg   <= '0;
        end else begin
            basis_reg <= basis_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N; k++) begin
            if (adv[k] && vld_in[k]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign s_ready       = adv[0];
    assign m_valid       = vld_reg[N-1];
    assign m_packed_out  = pipe_reg[N-1].packed_val;
    assign m_mu_out      = pipe_reg[N-1].mu;
    assign m_nu_out      = pipe_reg[N-1].nu;
    assign m_lam_out     = pipe_reg[N-1].lam;
    assign m_sig_out     = pipe_reg[N-1].sig;
    assign m_range_error = pipe_reg[N-1].err;

endmodule

// File: sv/sqim_checker.sv
// ----------------------------------------------------------------------------
// sqim_checker
// port-level checks on the result channel of the symmetric quad index map
// ----------------------------------------------------------------------------
`include "symmetric_quad_index_map_core_defines.svh"

module sqim_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [sqim_pkg::PACKED_W-1:0] m_packed_out,
    input logic [sqim_pkg::ORB_W-1:0]    m_mu_out,
    input logic [sqim_pkg::ORB_W-1:0]    m_nu_out,
    input logic [sqim_pkg::ORB_W-1:0]    m_lam_out,
    input logic [sqim_pkg::ORB_W-1:0]    m_sig_out,
    input logic                          m_range_error
);

    // a stalled word stays put
    `SQIM_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_packed_out) && $stable(m_mu_out) && $stable(m_range_error), "stalled word changed")

    // an error word carries nothing else
    `SQIM_ASSERT_SAME(a_err_zero, m_valid && m_range_error, m_packed_out == '0 && m_mu_out == '0 && m_nu_out == '0 && m_lam_out == '0 && m_sig_out == '0, "error word not cleared")

    // forward and reverse results never mix
    `SQIM_ASSERT_SAME(a_one_mode, m_valid, m_packed_out == '0 || (m_mu_out == '0 && m_nu_out == '0 && m_lam_out == '0 && m_sig_out == '0), "packed and orbital fields both set")

    // larger index first in each pair
    `SQIM_ASSERT_SAME(a_pair_order, m_valid, m_mu_out >= m_nu_out && m_lam_out >= m_sig_out, "pair out of order")

endmodule

bind symmetric_quad_index_map_core sqim_checker u_sqim_checker (.*);
